/* rtl/core/lwg_pkg.sv */
// ----------------------------------------------------------------------------
// lwg_pkg
// Shared types and constants of the gated row lifting wavelet.
// ----------------------------------------------------------------------------
package lwg_pkg;

    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 11;
    localparam int GATE_W   = 15;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // register index, taken from paddr[2]
    localparam logic REG_GATE = 1'b0;

    // pair operands handed from the sample sequencer to the lifting stages
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] even;
        logic signed [SAMPLE_W-1:0] odd;
        logic signed [SAMPLE_W-1:0] next_even;
        logic                       last;
        logic                       first;
        logic [INDEX_W-1:0]         index;
    } pair_t;

    // pair after the predict step
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] even;
        logic signed [SAMPLE_W-1:0] h;
        logic                       last;
        logic                       first;
        logic [INDEX_W-1:0]         index;
    } detail_t;

endpackage

/* rtl/core/lwg_stream_if.sv */
// ----------------------------------------------------------------------------
// lwg_stream_if
// Valid/ready channels for row samples and for coefficient pairs.
// ----------------------------------------------------------------------------
interface lwg_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [lwg_pkg::SAMPLE_W-1:0] sample;
    logic                                row_end;

    modport source (output valid, output sample, output row_end, input ready);
    modport sink   (input valid, input sample, input row_end, output ready);
endinterface

interface lwg_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [lwg_pkg::SAMPLE_W-1:0] lowpass;
    logic signed [lwg_pkg::SAMPLE_W-1:0] highpass;
    logic [lwg_pkg::INDEX_W-1:0]         pair_index;
    logic                                last_pair;

    modport source (output valid, output lowpass, output highpass, output pair_index,
                    output last_pair, input ready);
    modport sink   (input valid, input lowpass, input highpass, input pair_index,
                    input last_pair, output ready);
endinterface

/* rtl/core/lwg_cfg.sv */
// ----------------------------------------------------------------------------
// lwg_cfg
// APB register file holding the highpass gate threshold.
// ----------------------------------------------------------------------------
module lwg_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lwg_pkg::PADDR_W-1:0]  paddr,
    input  logic [lwg_pkg::PDATA_W-1:0]  pwdata,
    output logic [lwg_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [lwg_pkg::GATE_W-1:0]   gate_threshold
);

    logic [lwg_pkg::GATE_W-1:0] gate_reg;
    logic [lwg_pkg::GATE_W-1:0] gate_next;
    logic                       reg_sel;

    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    always_comb
    begin
        gate_next = gate_reg;
        if (psel && penable && pwrite && (reg_sel == lwg_pkg::REG_GATE))
        begin
            gate_next = pwdata[lwg_pkg::GATE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg <= '0;
        end
        else
        begin
            gate_reg <= gate_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel == lwg_pkg::REG_GATE)
        begin
            prdata = {{(lwg_pkg::PDATA_W - lwg_pkg::GATE_W){1'b0}}, gate_reg};
        end
    end

    assign gate_threshold = gate_reg;

endmodule

/* rtl/core/lwg_front.sv */
// ----------------------------------------------------------------------------
// lwg_front
// Sample sequencer: tracks even/odd phase, holds neighbors, registers pairs.
// ----------------------------------------------------------------------------
module lwg_front #(
    parameter int MAX_HALF_LEN = 2048
) (
    input  logic            clk,
    input  logic            rst_n,
    lwg_in_if.sink          samples,
    output logic            pair_valid,
    output lwg_pkg::pair_t  pair,
    input  logic            pair_ready
);

    localparam int CNT_W = (MAX_HALF_LEN > 1) ? $clog2(MAX_HALF_LEN) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_HALF_LEN - 1);

    logic                                phase_reg, phase_next;
    logic                                pending_reg, pending_next;
    logic signed [lwg_pkg::SAMPLE_W-1:0] even_reg, even_next;
    logic signed [lwg_pkg::SAMPLE_W-1:0] odd_reg, odd_next;
    logic [CNT_W-1:0]                    count_reg, count_next;
    logic                                s1_valid_reg, s1_valid_next;
    lwg_pkg::pair_t                      s1_reg, s1_next;

    logic                                accept;
    logic                                make;
    logic [CNT_W+lwg_pkg::INDEX_W-1:0]   count_ext;

    assign samples.ready = !s1_valid_reg || pair_ready;
    assign accept        = samples.valid && samples.ready;
    assign count_ext     = {{lwg_pkg::INDEX_W{1'b0}}, count_reg};

    always_comb
    begin
        phase_next      = phase_reg;
        pending_next    = pending_reg;
        even_next       = even_reg;
        odd_next        = odd_reg;
        count_next      = count_reg;
        make            = 1'b0;
        s1_next         = s1_reg;
        s1_next.even    = even_reg;
        s1_next.odd     = odd_reg;
        s1_next.first   = (count_reg == '0);
        s1_next.index   = count_ext[lwg_pkg::INDEX_W-1:0];
        s1_next.last    = 1'b0;
        s1_next.next_even = samples.sample;
        if (accept)
        begin
            if (!phase_reg)
            begin
                // even sample closes the waiting pair
                make         = pending_reg;
                even_next    = samples.sample;
                pending_next = 1'b0;
                phase_next   = 1'b1;
                if (pending_reg && (count_reg != CNT_MAX))
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            else
            begin
                odd_next   = samples.sample;
                phase_next = 1'b0;
                if (samples.row_end)
                begin
                    make         = 1'b1;
                    s1_next.odd  = samples.sample;
                    s1_next.last = 1'b1;
                    pending_next = 1'b0;
                    count_next   = '0;
                end
                else
                begin
                    pending_next = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = make;
        end
        else if (pair_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= 1'b0;
            pending_reg  <= 1'b0;
            even_reg     <= '0;
            odd_reg      <= '0;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pending_reg  <= pending_next;
            even_reg     <= even_next;
            odd_reg      <= odd_next;
            count_reg    <= count_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // hold the pair while stalled, load only on a transfer that makes one
    always_ff @(posedge clk)
    begin
        if (accept && make)
        begin
            s1_reg <= s1_next;
        end
    end

    assign pair_valid = s1_valid_reg;
    assign pair       = s1_reg;

`ifndef ASSERT_OFF
    a_row_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg && samples.row_end |=> (count_reg == '0) && !pending_reg)
        else $error("row state not cleared after row end");

    a_pair_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !pair_ready |=> s1_valid_reg && $stable(s1_reg))
        else $error("pair lost while stalled");

    a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_reg.first |-> (s1_reg.index == '0))
        else $error("first pair with nonzero index");
`endif

endmodule

/* rtl/core/lwg_lift.sv */
// ----------------------------------------------------------------------------
// lwg_lift
// Predict and update lifting steps with highpass gating and result register.
// ----------------------------------------------------------------------------
module lwg_lift (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pair_valid,
    input  lwg_pkg::pair_t              pair,
    output logic                        pair_ready,
    input  logic [lwg_pkg::GATE_W-1:0]  gate_threshold,
    lwg_out_if.source                   coefs
);

    logic                                s2_valid_reg, s2_valid_next;
    lwg_pkg::detail_t                    s2_reg, s2_next;
    logic signed [lwg_pkg::SAMPLE_W-1:0] prev_h_reg;
    logic                                out_valid_reg, out_valid_next;
    logic signed [lwg_pkg::SAMPLE_W-1:0] low_reg, low_next;
    logic signed [lwg_pkg::SAMPLE_W-1:0] high_reg, high_next;
    logic [lwg_pkg::INDEX_W-1:0]         index_reg;
    logic                                last_reg;

    logic        out_adv;
    logic        s2_move;
    logic        s1_move;

    logic signed [16:0] pair_sum, pair_adj, pair_half, odd_ext, even_ext, h_wide;
    logic signed [16:0] h_ext, prev_ext, hp_sum, hp_adj, hp_q, h_adj, h_half;
    logic signed [16:0] s2_even_ext, l_wide, gate_pos, gate_neg;
    logic               gated;

    assign out_adv    = !out_valid_reg || coefs.ready;
    assign pair_ready = !s2_valid_reg || out_adv;
    assign s1_move    = pair_valid && pair_ready;
    assign s2_move    = s2_valid_reg && out_adv;

    // predict: h = odd - (even + next_even) / 2, or odd - even on the last pair
    always_comb
    begin
        even_ext = {pair.even[15], pair.even};
        odd_ext  = {pair.odd[15], pair.odd};
        pair_sum = even_ext + {pair.next_even[15], pair.next_even};
        pair_adj = pair_sum + (pair_sum[16] ? 17'sd1 : 17'sd0);
        pair_half = pair_adj >>> 1;
        if (pair.last)
        begin
            h_wide = odd_ext - even_ext;
        end
        else
        begin
            h_wide = odd_ext - pair_half;
        end
        s2_next.even  = pair.even;
        s2_next.h     = h_wide[15:0];
        s2_next.last  = pair.last;
        s2_next.first = pair.first;
        s2_next.index = pair.index;
    end

    // update: l = even + (h + prev_h) / 4, or even + h / 2 on the first pair
    always_comb
    begin
        h_ext       = {s2_reg.h[15], s2_reg.h};
        prev_ext    = {prev_h_reg[15], prev_h_reg};
        s2_even_ext = {s2_reg.even[15], s2_reg.even};
        hp_sum      = h_ext + prev_ext;
        hp_adj      = hp_sum + (hp_sum[16] ? 17'sd3 : 17'sd0);
        hp_q        = hp_adj >>> 2;
        h_adj       = h_ext + (h_ext[16] ? 17'sd1 : 17'sd0);
        h_half      = h_adj >>> 1;
        l_wide      = s2_even_ext + (s2_reg.first ? h_half : hp_q);
        low_next    = l_wide[15:0];
        gate_pos    = $signed({2'b00, gate_threshold});
        gate_neg    = -gate_pos;
        gated       = (h_ext > gate_neg) && (h_ext < gate_pos);
        high_next   = gated ? '0 : s2_reg.h;
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (pair_ready)
        begin
            s2_valid_next = pair_valid;
        end
        out_valid_next = out_valid_reg;
        if (out_adv)
        begin
            out_valid_next = s2_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_reg <= s2_next;
        end
        if (s2_move)
        begin
            low_reg    <= low_next;
            high_reg   <= high_next;
            index_reg  <= s2_reg.index;
            last_reg   <= s2_reg.last;
            // ungated detail feeds the next pair's update
            prev_h_reg <= s2_reg.h;
        end
    end

    assign coefs.valid      = out_valid_reg;
    assign coefs.lowpass    = low_reg;
    assign coefs.highpass   = high_reg;
    assign coefs.pair_index = index_reg;
    assign coefs.last_pair  = last_reg;

`ifndef ASSERT_OFF
    a_prev_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        s2_move |=> (prev_h_reg == $past(s2_reg.h)))
        else $error("previous detail not updated");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pair_ready |-> s2_valid_reg && out_valid_reg && !coefs.ready)
        else $error("stall with free stage");

    a_detail_held: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !out_adv |=> s2_valid_reg && $stable(s2_reg))
        else $error("detail lost while stalled");
`endif

endmodule

/* rtl/core/lifting_wavelet_row_with_gate.sv */
// ----------------------------------------------------------------------------
// lifting_wavelet_row_with_gate
// Forward one-level 5/3 integer lifting over a row with a highpass gate.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle unless the coefficient channel stalls; a pair
//   result per two samples. A pair passes the pair register, predict stage and
//   update stage after the transfer of the sample that completes it.
// Reset: rst_n clears phase, pair count, pending pair and the gate threshold;
//   the pipeline comes up empty.
// ----------------------------------------------------------------------------
module lifting_wavelet_row_with_gate #(
    parameter int MAX_HALF_LEN = 2048
) (
    input  logic                         clk,
    input  logic                         rst_n,
    lwg_in_if.sink                       samples,
    lwg_out_if.source                    coefs,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lwg_pkg::PADDR_W-1:0]  paddr,
    input  logic [lwg_pkg::PDATA_W-1:0]  pwdata,
    output logic [lwg_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    logic [lwg_pkg::GATE_W-1:0] gate_threshold;
    logic                       pair_valid;
    logic                       pair_ready;
    lwg_pkg::pair_t             pair;

    lwg_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .gate_threshold (gate_threshold)
    );

    lwg_front #(
        .MAX_HALF_LEN (MAX_HALF_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .pair_valid (pair_valid),
        .pair       (pair),
        .pair_ready (pair_ready)
    );

    lwg_lift u_lift (
        .clk            (clk),
        .rst_n          (rst_n),
        .pair_valid     (pair_valid),
        .pair           (pair),
        .pair_ready     (pair_ready),
        .gate_threshold (gate_threshold),
        .coefs          (coefs)
    );

endmodule

/* sim/tb_lifting_wavelet_row_with_gate.sv */
// ----------------------------------------------------------------------------
// tb_lifting_wavelet_row_with_gate
// Self-checking bench for the gated row lifting wavelet. Rows of samples go
// in through the sample channel. Each coefficient pair that comes out is
// compared field by field with the directed table's expected pair or with a
// lifting model held in the bench. The bench runs a directed table first, then
// random rows under several gate levels and flow-control patterns.
// ----------------------------------------------------------------------------
module tb_lifting_wavelet_row_with_gate;

    localparam int SAMPLE_W = lwg_pkg::SAMPLE_W;
    localparam int INDEX_W  = lwg_pkg::INDEX_W;
    localparam int GATE_W   = lwg_pkg::GATE_W;
    localparam int PADDR_W  = lwg_pkg::PADDR_W;
    localparam int PDATA_W  = lwg_pkg::PDATA_W;

    localparam int MAX_HALF_LEN   = 2048;
    localparam int DRAIN_CYCLES   = 8;
    localparam int QUIET_LIMIT    = 3000;

    localparam logic [PADDR_W-1:0] GATE_ADDR  = {lwg_pkg::REG_GATE, 2'b00};
    localparam logic [PADDR_W-1:0] SPARE_ADDR = {~lwg_pkg::REG_GATE, 2'b00};
    localparam logic [GATE_W-1:0]  GATE_MAX   = {GATE_W{1'b1}};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] lowpass;
        logic signed [SAMPLE_W-1:0] highpass;
        logic [INDEX_W-1:0]         pair_index;
        logic                       last_pair;
    } coef_t;

    typedef enum logic {SAMPLE_ITEM, GATE_WRITE} step_kind_t;

    typedef struct packed {
        step_kind_t          kind;
        logic [SAMPLE_W-1:0] value;
        logic                row_end;
        logic                typed;
        coef_t               want;
    } step_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    lwg_in_if  samples_ch ();
    lwg_out_if coefs_ch ();

    lifting_wavelet_row_with_gate #(
        .MAX_HALF_LEN (MAX_HALF_LEN)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .coefs   (coefs_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // lifting model state
    logic              row_odd_next = 1'b0;
    int                row_even     = 0;
    int                row_odd      = 0;
    int                row_prev_h   = 0;
    int                row_pairs    = 0;
    logic              row_waiting  = 1'b0;
    logic [GATE_W-1:0] gate_level   = '0;

    coef_t coefs_due [$];

    int unsigned send_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;
    int          sink_hold_req  = 0;
    int          fail_count     = 0;
    int          quiet_cycles   = 0;

    step_t plan [27] = '{
        '{SAMPLE_ITEM, 16'd100,    1'b1, 1'b0, '0},
        '{SAMPLE_ITEM, 16'd300,    1'b1, 1'b1, '{16'sd200, 16'sd200, 11'd0, 1'b1}},
        '{SAMPLE_ITEM, 16'h7FFF,   1'b0, 1'b0, '0},
        '{SAMPLE_ITEM, 16'h8000,   1'b1, 1'b1, '{16'sh7FFF, 16'sd1, 11'd0, 1'b1}},
        '{SAMPLE_ITEM, 16'h8000,   1'b0, 1'b0, '0},
        '{SAMPLE_ITEM, 16'h7FFF,   1'b1, 1'b1, '{16'sh8000, -16'sd1, 11'd0, 1'b1}},
        '{SAMPLE_ITEM, 16'd10,     1'b0, 1'b0, '0},
        '{SAMPLE_ITEM, 16'd20,     1'b0, 1'b0, '0},
        '{SAMPLE_ITEM, 16'd30,     1'b0, 1'b1, '{16'sd10, 16'sd0, 11'd0, 1'b0}},
        '{SAMPLE_ITEM, -16'sd7,    1'b0, 1'b0, '0},
        '{SAMPLE_ITEM, 16'd1,      1'b0, 1'b0, '0},
        '{SAMPLE_ITEM, 16'd5,      1'b1, 1'b0, '0},
        '{SAMPLE_ITEM, 16'h7FFF,   1'b0, 1'b0, '0},
        '{SAMPLE_ITEM, 16'h8000,   1'b0, 1'b0, '0},
        '{SAMPLE_ITEM, 16'h7FFF,   1'b0, 1'b0, '0},
        '{SAMPLE_ITEM, 16'h7FFF,   1'b0, 1'b0, '0},
        '{SAMPLE_ITEM, 16'h8000,   1'b0, 1'b0, '0},
        '{SAMPLE_ITEM, 16'h8000,   1'b1, 1'b0, '0},
        '{GATE_WRITE,  16'd200,    1'b0, 1'b0, '0},
        '{SAMPLE_ITEM, 16'd0,      1'b0, 1'b0, '0},
        '{SAMPLE_ITEM, 16'd200,    1'b1, 1'b1, '{16'sd100, 16'sd200, 11'd0, 1'b1}},
        '{SAMPLE_ITEM, 16'd0,      1'b0, 1'b0, '0},
        '{SAMPLE_ITEM, 16'd199,    1'b1, 1'b1, '{16'sd99, 16'sd0, 11'd0, 1'b1}},
        '{SAMPLE_ITEM, 16'd0,      1'b0, 1'b0, '0},
        '{SAMPLE_ITEM, -16'sd200,  1'b1, 1'b1, '{-16'sd100, -16'sd200, 11'd0, 1'b1}},
        '{SAMPLE_ITEM, 16'd0,      1'b0, 1'b0, '0},
        '{SAMPLE_ITEM, -16'sd199,  1'b1, 1'b1, '{-16'sd99, 16'sd0, 11'd0, 1'b1}}
    };

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int to_s16(input int v);
        logic signed [SAMPLE_W-1:0] t;
        t = v[SAMPLE_W-1:0];
        return int'(t);
    endfunction

    task automatic pair_coefs(input int ev, input int od, input int nx, input logic last,
                              output coef_t c);
        int h;
        int l;
        int gate_i;
        gate_i = int'(gate_level);
        if (last)
            h = to_s16(od - ev);
        else
            h = to_s16(od - (ev + nx) / 2);
        if (row_pairs == 0)
            l = to_s16(ev + h / 2);
        else
            l = to_s16(ev + (h + row_prev_h) / 4);
        c.lowpass    = l[SAMPLE_W-1:0];
        c.highpass   = (h > -gate_i && h < gate_i) ? '0 : h[SAMPLE_W-1:0];
        c.pair_index = row_pairs[INDEX_W-1:0];
        c.last_pair  = last;
        // the ungated detail feeds the next lowpass
        row_prev_h = h;
        if (row_pairs < MAX_HALF_LEN - 1)
            row_pairs++;
    endtask

    task automatic lift_step(input logic [SAMPLE_W-1:0] value, input logic flag,
                             output bit made, output coef_t c);
        int s;
        s    = to_s16(int'(value));
        made = 1'b0;
        c    = '0;
        if (!row_odd_next)
        begin
            // a waiting pair completes on the next even sample; end flag is ignored here
            if (row_waiting)
            begin
                pair_coefs(row_even, row_odd, s, 1'b0, c);
                made = 1'b1;
            end
            row_even     = s;
            row_waiting  = 1'b0;
            row_odd_next = 1'b1;
        end
        else
        begin
            row_odd      = s;
            row_odd_next = 1'b0;
            if (flag)
            begin
                pair_coefs(row_even, s, 0, 1'b1, c);
                made        = 1'b1;
                row_waiting = 1'b0;
                row_pairs   = 0;
                row_prev_h  = 0;
            end
            else
                row_waiting = 1'b1;
        end
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic flag,
                               input logic typed, input coef_t typed_coef);
        bit    made;
        coef_t c;
        while ($urandom_range(99) < send_idle_pct)
        begin
            samples_ch.valid <= 1'b0;
            @(posedge clk);
        end
        samples_ch.valid   <= 1'b1;
        samples_ch.sample  <= value;
        samples_ch.row_end <= flag;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        lift_step(value, flag, made, c);
        if (made)
            coefs_due.push_back(typed ? typed_coef : c);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(3))
            0: return SAMPLE_W'($urandom);
            1: return SAMPLE_W'($urandom_range(64)) - SAMPLE_W'(32);
            2: return ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
            default: return SAMPLE_W'($urandom_range(4000)) - SAMPLE_W'(2000);
        endcase
    endfunction

    // mostly whole rows; a stray end flag on an even sample, rows left open
    // and lone samples now and then
    task automatic send_rows(input int n_items);
        int sent;
        int pairs;
        sent = 0;
        while (sent < n_items)
        begin
            pairs = ($urandom_range(9) == 0) ? $urandom_range(200, 30) : $urandom_range(8, 1);
            for (int p = 0; p < pairs; p++)
            begin
                send_sample(pick_sample(), $urandom_range(19) == 0, 1'b0, '0);
                send_sample(pick_sample(), p == pairs - 1 && $urandom_range(15) != 0,
                            1'b0, '0);
                sent += 2;
            end
            if ($urandom_range(12) == 0)
            begin
                send_sample(pick_sample(), 1'($urandom_range(1)), 1'b0, '0);
                sent++;
            end
        end
    endtask

    task automatic settle();
        samples_ch.valid <= 1'b0;
        while (coefs_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic [PADDR_W-1:0] addr, input logic is_write,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // write the gate with junk above it, poke the unused slot, read the gate back
    task automatic set_gate(input logic [GATE_W-1:0] level);
        logic [PDATA_W-1:0] word;
        word = $urandom;
        word[GATE_W-1:0] = level;
        apb_access(GATE_ADDR, 1'b1, word, word);
        gate_level = level;
        apb_access(SPARE_ADDR, 1'b1, $urandom, word);
        apb_access(GATE_ADDR, 1'b0, '0, word);
        if (word[GATE_W-1:0] !== gate_level)
        begin
            $error("gate_threshold: expected %0d, got %0d", gate_level, word[GATE_W-1:0]);
            fail_count++;
        end
    endtask

    initial
    begin : coef_sink
        int hold_len;
        coefs_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_req != 0)
            begin
                hold_len      = sink_hold_req;
                sink_hold_req = 0;
                coefs_ch.ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
            end
            coefs_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin : coef_check
        coef_t want;
        if (rst_n && coefs_ch.valid && coefs_ch.ready)
        begin
            if (coefs_due.size() == 0)
            begin
                $error("coefficient transfer with none expected: lowpass %0d highpass %0d",
                       coefs_ch.lowpass, coefs_ch.highpass);
                fail_count++;
            end
            else
            begin
                want = coefs_due.pop_front();
                if (coefs_ch.lowpass !== want.lowpass)
                begin
                    $error("lowpass: expected %0d, got %0d", want.lowpass, coefs_ch.lowpass);
                    fail_count++;
                end
                if (coefs_ch.highpass !== want.highpass)
                begin
                    $error("highpass: expected %0d, got %0d", want.highpass, coefs_ch.highpass);
                    fail_count++;
                end
                if (coefs_ch.pair_index !== want.pair_index)
                begin
                    $error("pair_index: expected %0d, got %0d", want.pair_index,
                           coefs_ch.pair_index);
                    fail_count++;
                end
                if (coefs_ch.last_pair !== want.last_pair)
                begin
                    $error("last_pair: expected %0d, got %0d", want.last_pair,
                           coefs_ch.last_pair);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((samples_ch.valid && samples_ch.ready) || (coefs_ch.valid && coefs_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("lifting_wavelet_row_with_gate: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        samples_ch.valid   = 1'b0;
        samples_ch.sample  = '0;
        samples_ch.row_end = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows run with the gate at its reset value until the table sets it
        foreach (plan[i])
        begin
            if (plan[i].kind == GATE_WRITE)
            begin
                settle();
                set_gate(plan[i].value[GATE_W-1:0]);
            end
            else
                send_sample(plan[i].value, plan[i].row_end, plan[i].typed, plan[i].want);
        end

        settle();
        set_gate(GATE_MAX);
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        send_rows(400);

        settle();
        set_gate(GATE_W'(1));
        send_idle_pct  = 87;
        sink_stall_pct = 0;
        send_rows(400);

        settle();
        set_gate(GATE_W'($urandom_range(300)));
        send_idle_pct  = 0;
        sink_stall_pct = 87;
        send_rows(400);

        settle();
        set_gate(GATE_W'($urandom));
        send_idle_pct  = 28;
        sink_stall_pct = 28;
        send_rows(400);

        // hold the sink off while samples keep coming so the pipeline backs up
        settle();
        set_gate('0);
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        sink_hold_req  = 400;
        send_rows(300);

        settle();
        if (fail_count == 0)
            $display("lifting_wavelet_row_with_gate: match");
        else
            $display("lifting_wavelet_row_with_gate: mismatch");
        $finish;
    end

endmodule
